@@ rtl/core/spal_pkg.sv @@
package spal_pkg;

  localparam int unsigned ACTIVE_DEPTH = 16;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned EDGE_W = 16;
  localparam int unsigned FAR_W  = 18;
  localparam int unsigned CNT_W  = $clog2(ACTIVE_DEPTH + 1);
  localparam int unsigned IDX_W  = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } spal_state_e;

endpackage

@@ rtl/core/sweep_prune_active_list.sv @@
// Sweep-and-prune active list for one axis. Boxes must arrive sorted by their
// leading edge on the axis chosen by sweep_axis (0: x_left and box_width, 1: y_top
// and box_height); a transaction with start_of_list set empties the list first.
// Each box evicts every stored entry whose far edge (leading edge plus size) is at
// or before its own leading edge, emits one pair (stored id, new id) per survivor
// in insertion order with tlast on the final pair, and is then appended. When the
// list already holds ACTIVE_DEPTH survivors the box is dropped and tuser
// (list_overflow) is set on that final pair. A box that meets no survivor emits
// nothing. A box holds the block while it is taken, while each stored entry is
// walked, while the end of the list is seen and while it is appended; only then
// is a new box taken. The single compare-and-compact sequencer walks the list one
// entry per cycle while the output register can take each survivor's pair.
// Output back-pressure stretches the walk, but a new box is taken while the last
// pair of the previous one still waits in the output register. sweep_axis may
// only be written while the block is idle.
module sweep_prune_active_list (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,   // sweep_axis

  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // entity_id, x_left, y_top, box_width, box_height
  input  logic [spal_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                              s_axis_tuser_i, // start_of_list

  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [spal_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o, // earlier_id, newer_id
  output logic                              m_axis_tlast_o, // last_of_run
  output logic                              m_axis_tuser_o  // list_overflow
);
  import spal_pkg::*;

  // input field slices
  logic [ID_W-1:0]   in_id;
  logic [EDGE_W-1:0] in_x, in_y, in_w, in_h;
  assign in_id = s_axis_tdata_i[15:0];
  assign in_x  = s_axis_tdata_i[31:16];
  assign in_y  = s_axis_tdata_i[47:32];
  assign in_w  = s_axis_tdata_i[63:48];
  assign in_h  = s_axis_tdata_i[79:64];

  logic axis_q;

  // sequencer state
  spal_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;      // entries in the list
  logic [CNT_W-1:0] rd_q, rd_d;        // walk position
  logic [CNT_W-1:0] keep_q, keep_d;    // compaction position
  logic             pend_vld_q, pend_vld_d;
  logic [ID_W-1:0]  pend_id_q, pend_id_d;

  // current box
  logic [ID_W-1:0]  cur_id_q;
  logic [FAR_W-1:0] cur_lead_q, cur_far_q;

  // active list storage
  logic [ID_W-1:0]  ids_q [ACTIVE_DEPTH];
  logic [FAR_W-1:0] fars_q[ACTIVE_DEPTH];

  // output register
  logic            m_vld_q, m_vld_d;
  logic [ID_W-1:0] m_early_q, m_newer_q;
  logic            m_last_q, m_ovf_q;

  logic             in_acc;
  logic             out_free;
  logic [ID_W-1:0]  rd_id;
  logic [FAR_W-1:0] rd_far;
  logic             survive;
  logic [EDGE_W-1:0] sel_lead, sel_size;
  logic [FAR_W-1:0] lead_ext, far_sum;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [ID_W-1:0]  wr_id;
  logic [FAR_W-1:0] wr_far;
  logic             push, push_last, push_ovf;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_vld_q || m_axis_tready_i;

  // far edge of the arriving box on the swept axis
  assign sel_lead = axis_q ? in_y : in_x;
  assign sel_size = axis_q ? in_h : in_w;
  assign lead_ext = {{(FAR_W - EDGE_W){sel_lead[EDGE_W-1]}}, sel_lead};
  assign far_sum  = lead_ext + {{(FAR_W - EDGE_W){1'b0}}, sel_size};

  // single read port at the walk position, one signed compare
  assign rd_id   = ids_q[rd_q[IDX_W-1:0]];
  assign rd_far  = fars_q[rd_q[IDX_W-1:0]];
  assign survive = $signed(cur_lead_q) < $signed(rd_far);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_d       = rd_q;
    keep_d     = keep_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    wr_en      = 1'b0;
    wr_idx     = keep_q[IDX_W-1:0];
    wr_id      = rd_id;
    wr_far     = rd_far;
    push       = 1'b0;
    push_last  = 1'b0;
    push_ovf   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          state_d    = StScan;
          rd_d       = '0;
          keep_d     = '0;
          pend_vld_d = 1'b0;
          if (s_axis_tuser_i) begin
            cnt_d = '0;
          end
        end
      end
      StScan: begin
        if (rd_q == cnt_q) begin
          state_d = StFinish;
        end else if (!survive) begin
          rd_d = rd_q + CNT_W'(1);
        end else if (!pend_vld_q || out_free) begin
          // previous survivor is known not to be the last one: send it
          push       = pend_vld_q;
          pend_vld_d = 1'b1;
          pend_id_d  = rd_id;
          wr_en      = 1'b1;
          keep_d     = keep_q + CNT_W'(1);
          rd_d       = rd_q + CNT_W'(1);
        end
      end
      StFinish: begin
        if (!pend_vld_q || out_free) begin
          push       = pend_vld_q;
          push_last  = 1'b1;
          push_ovf   = (keep_q == CNT_W'(ACTIVE_DEPTH));
          pend_vld_d = 1'b0;
          wr_id      = cur_id_q;
          wr_far     = cur_far_q;
          if (keep_q < CNT_W'(ACTIVE_DEPTH)) begin
            wr_en = 1'b1;
            cnt_d = keep_q + CNT_W'(1);
          end else begin
            cnt_d = keep_q;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    m_vld_d = m_vld_q;
    if (push) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      rd_q       <= '0;
      keep_q     <= '0;
      pend_vld_q <= 1'b0;
      m_vld_q    <= 1'b0;
      axis_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_q       <= rd_d;
      keep_q     <= keep_d;
      pend_vld_q <= pend_vld_d;
      m_vld_q    <= m_vld_d;
      if (cfg_we_i) begin
        axis_q <= cfg_wdata_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    if (in_acc) begin
      cur_id_q   <= in_id;
      cur_lead_q <= lead_ext;
      cur_far_q  <= far_sum;
    end
    if (wr_en) begin
      ids_q[wr_idx]  <= wr_id;
      fars_q[wr_idx] <= wr_far;
    end
    if (push) begin
      m_early_q <= pend_id_q;
      m_newer_q <= cur_id_q;
      m_last_q  <= push_last;
      m_ovf_q   <= push_ovf;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {m_newer_q, m_early_q};
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_ovf_q;

endmodule

@@ rtl/core/spal_checker.sv @@
module spal_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [spal_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input logic                              m_axis_tlast_o,
  input logic                              m_axis_tuser_o
);

  // a taken box keeps the block busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again right after a transaction");

  // overflow only flags the final pair of a box
  a_ovf_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("overflow on a pair that is not last");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind sweep_prune_active_list spal_checker u_spal_checker (.*);

@@ verif/spal_pair_checker.sv @@
module spal_pair_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           s_valid_i,
  input  logic                           s_ready_i,
  input  logic [spal_pkg::IN_DATA_W-1:0] s_data_i,
  input  logic                           s_user_i,
  input  logic                           m_valid_i,
  input  logic                           m_ready_i,
  input  logic [spal_pkg::OUT_DATA_W-1:0] m_data_i,
  input  logic                           m_last_i,
  input  logic                           m_user_i,
  output int                             mismatch_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] earlier_id;
    logic [15:0] newer_id;
    logic        list_overflow;
    logic        last_of_run;
  } pair_t;

  pair_t              pair_queue[$];
  logic [15:0]        active_ids [spal_pkg::ACTIVE_DEPTH];
  logic signed [17:0] active_far [spal_pkg::ACTIVE_DEPTH];
  int unsigned        active_count;
  logic               sweep_axis;

  initial begin
    mismatch_count_o = 0;
    pending_o = 0;
  end

  task automatic note_mismatch(input string what, input pair_t want, input pair_t seen);
    if (mismatch_count_o < 10)
      $display("%0t pair %s: expected %04h/%04h ovf %0b last %0b, got %04h/%04h ovf %0b last %0b",
               $time, what, want.earlier_id, want.newer_id, want.list_overflow,
               want.last_of_run, seen.earlier_id, seen.newer_id, seen.list_overflow,
               seen.last_of_run);
    mismatch_count_o++;
  endtask

  task automatic check_pair();
    pair_t seen;
    pair_t want;
    seen.earlier_id    = m_data_i[15:0];
    seen.newer_id      = m_data_i[31:16];
    seen.list_overflow = m_user_i;
    seen.last_of_run   = m_last_i;
    if (pair_queue.size() == 0) begin
      note_mismatch("unexpected", '0, seen);
    end else begin
      want = pair_queue.pop_front();
      if (want !== seen) note_mismatch("mismatch", want, seen);
    end
  endtask

  // evict, emit survivors in order, then append or drop
  task automatic sweep_box(input logic [spal_pkg::IN_DATA_W-1:0] data, input logic start);
    logic [15:0]        id;
    logic [15:0]        lead_raw;
    logic [15:0]        size;
    logic signed [17:0] lead_pos;
    logic signed [17:0] far_pos;
    int unsigned        keep;
    int unsigned        i;
    logic               full;
    pair_t              p;
    id = data[15:0];
    if (sweep_axis) begin
      lead_raw = data[47:32];
      size     = data[79:64];
    end else begin
      lead_raw = data[31:16];
      size     = data[63:48];
    end
    lead_pos = {{2{lead_raw[15]}}, lead_raw};
    far_pos  = lead_pos + {2'b00, size};
    if (start) active_count = 0;
    keep = 0;
    for (i = 0; i < active_count; i++) begin
      if (lead_pos < active_far[i]) begin
        active_ids[keep] = active_ids[i];
        active_far[keep] = active_far[i];
        keep++;
      end
    end
    full = (keep == spal_pkg::ACTIVE_DEPTH);
    for (i = 0; i < keep; i++) begin
      p.earlier_id    = active_ids[i];
      p.newer_id      = id;
      p.last_of_run   = (i == keep - 1);
      p.list_overflow = full && (i == keep - 1);
      pair_queue.insert(pair_queue.size(), p);
    end
    active_count = keep;
    if (!full) begin
      active_ids[active_count] = id;
      active_far[active_count] = far_pos;
      active_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count = 0;
      sweep_axis = 1'b0;
      pair_queue.delete();
    end else begin
      if (m_valid_i && m_ready_i) check_pair();
      if (s_valid_i && s_ready_i) sweep_box(s_data_i, s_user_i);
      if (cfg_we_i) sweep_axis = cfg_wdata_i;
    end
    pending_o = pair_queue.size();
  end

endmodule

@@ verif/sweep_prune_active_list_test.sv @@
module sweep_prune_active_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spal_pkg::*;

  // settle margin: room for one box to walk a full list, with padding on top
  localparam int SETTLE_CYCLES = ACTIVE_DEPTH + 8;
  localparam int PHASE_ITEMS   = 89;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;

  // config port, idle low from time zero
  logic                  cfg_we = 1'b0;
  logic                  cfg_wdata = 1'b0;

  // box stream into the block
  logic                  box_valid = 1'b0;
  logic                  box_ready;
  // entity_id, x_left, y_top, box_width, box_height
  logic [IN_DATA_W-1:0]  box_data = '0;
  logic                  box_start = 1'b0;   // start_of_list

  // pair stream out of the block
  logic                  pair_valid;
  logic                  pair_ready = 1'b0;
  logic [OUT_DATA_W-1:0] pair_data;          // earlier_id, newer_id
  logic                  pair_last;          // last_of_run
  logic                  pair_overflow;      // list_overflow

  int                    mismatch_count;
  int                    pending;
  int                    burst_left = 0;

  // receiver stall pattern: rotates every cycle, reshuffled instead whenever pattern_age wraps
  logic [15:0]           ready_pattern = 16'hFFFF;
  int unsigned           pattern_age = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sweep_prune_active_list uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (box_valid),
    .s_axis_tready_o (box_ready),
    .s_axis_tdata_i  (box_data),
    .s_axis_tuser_i  (box_start),
    .m_axis_tvalid_o (pair_valid),
    .m_axis_tready_i (pair_ready),
    .m_axis_tdata_o  (pair_data),
    .m_axis_tlast_o  (pair_last),
    .m_axis_tuser_o  (pair_overflow)
  );

  spal_pair_checker pair_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_valid_i        (box_valid),
    .s_ready_i        (box_ready),
    .s_data_i         (box_data),
    .s_user_i         (box_start),
    .m_valid_i        (pair_valid),
    .m_ready_i        (pair_ready),
    .m_data_i         (pair_data),
    .m_last_i         (pair_last),
    .m_user_i         (pair_overflow),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // receiver side back-pressure
  always @(posedge clk_i) begin
    if (pattern_age == 63) begin
      pattern_age <= 0;
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 16'hFFFF;                              // no stalls
        1:       ready_pattern <= 16'($urandom) & 16'($urandom) | 16'h0001; // mostly stalled
        default: ready_pattern <= 16'($urandom) | 16'h0001;
      endcase
    end else begin
      pattern_age <= pattern_age + 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    pair_ready <= ready_pattern[0];
  end

  // one box transaction; each new burst opens with a gap in which box_valid is low
  task automatic send_box(input logic [15:0] id, input logic [15:0] x_left,
                          input logic [15:0] y_top, input logic [15:0] width,
                          input logic [15:0] height, input logic start);
    logic took;
    if (burst_left == 0) begin
      box_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    box_valid <= 1'b1;
    box_data  <= {height, width, y_top, x_left, id};
    box_start <= start;
    took = 1'b0;
    // ready is sampled mid-cycle, inputs only move at the rising edge
    while (!took) begin
      @(negedge clk_i);
      took = box_ready;
      @(posedge clk_i);
    end
    burst_left--;
  endtask

  // drain every expected pair, then let a box with no pairs finish too
  task automatic settle();
    box_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_axis(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // runs of sorted boxes on the swept axis, with some unsorted noise mixed in
  task automatic random_phase(input logic axis, input int n_items);
    int          sent;
    int          run_left;
    int          lead;
    int          step_max;
    logic [15:0] size;
    logic        first;
    sent = 0;
    run_left = 0;
    first = 1'b0;
    while (sent < n_items) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 40);
        lead = int'($urandom_range(0, 52767)) - 32768;
        case ($urandom_range(0, 2))
          0:       step_max = 4;
          1:       step_max = 64;
          default: step_max = 2000;
        endcase
        first = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: any field value, any order
        send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 1'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       size = 16'h0000;
          1:       size = 16'hFFFF;
          default: size = 16'($urandom_range(0, 16 * step_max));
        endcase
        if (axis)
          send_box(16'($urandom), 16'($urandom), 16'(lead), 16'($urandom), size, first);
        else
          send_box(16'($urandom), 16'(lead), 16'($urandom), size, 16'($urandom), first);
        lead += $urandom_range(0, step_max);
        if (lead > 32767) lead = 32767;
        first = 1'b0;
      end
      run_left--;
      sent++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, x axis
    write_axis(1'b0);
    // zero size box at the lowest edge, then a widest box that evicts it
    send_box(16'h0000, 16'h8000, 16'($urandom), 16'h0000, 16'($urandom), 1'b1);
    send_box(16'hFFFF, 16'h8000, 16'($urandom), 16'hFFFF, 16'($urandom), 1'b0);
    send_box(16'h1234, 16'h0000, 16'($urandom), 16'h0000, 16'($urandom), 1'b0);
    send_box(16'h5678, 16'h0000, 16'($urandom), 16'h000A, 16'($urandom), 1'b0);
    // highest edge plus widest size, evicts everything
    send_box(16'hA5A5, 16'h7FFF, 16'($urandom), 16'hFFFF, 16'($urandom), 1'b0);
    // fill the list to depth, then two boxes that find it full
    for (int k = 0; k < ACTIVE_DEPTH + 2; k++)
      send_box(16'h0100 + 16'(k), 16'(-200 + k), 16'($urandom), 16'hFFFF,
               16'($urandom), k == 0);
    settle();

    // directed, y axis: far edge at its maximum
    write_axis(1'b1);
    send_box(16'hBEEF, 16'($urandom), 16'h7FFF, 16'($urandom), 16'hFFFF, 1'b1);
    send_box(16'hCAFE, 16'($urandom), 16'h7FFF, 16'($urandom), 16'h0000, 1'b0);

    random_phase(1'b1, PHASE_ITEMS);
    settle();
    write_axis(1'b0);
    random_phase(1'b0, PHASE_ITEMS);
    settle();
    write_axis(1'b1);
    random_phase(1'b1, PHASE_ITEMS);
    settle();
    write_axis(1'b0);
    random_phase(1'b0, PHASE_ITEMS);
    settle();

    if (mismatch_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, many times the slowest expected run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/spal_pkg.sv
rtl/core/sweep_prune_active_list.sv
rtl/core/spal_checker.sv
verif/spal_pair_checker.sv
verif/sweep_prune_active_list_test.sv
